[rtl/pirl_pkg.sv]
package pirl_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = 5;
	// common width for comparing positions against the count
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [POS_W-1:0]   position;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		status_t            status;
		logic [4:0]         entry_count;
		logic               is_empty;
	} res_t;

	// per-cell update select
	typedef struct packed {
		logic load;
		logic take_prev;
		logic take_next;
	} cell_ctl_t;

endpackage

[rtl/positional_insert_remove_list.sv]
// ordered list held in a row of cells, one entry per cell
// the result is strobed on done in the cycle after the transaction is taken
// throughput: one transaction per cycle; busy stays low, every cell shifts at once
// reset: arst_n clears the entry count and the result strobe; cell contents stay
// undefined until written; the receiver cannot stall results
module positional_insert_remove_list (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pirl_pkg::cmd_t cmd,
	output logic           done,
	output pirl_pkg::res_t result
);
	import pirl_pkg::*;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  accept;
	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      cnt_x;
	logic                  do_insert;
	logic                  do_remove;
	status_t               status_nxt;
	logic [31:0]           removed_nxt;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] value_w;
	res_t                  res_q;
	logic                  done_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign pos_x   = CMP_W'(cmd.position);
	assign cnt_x   = CMP_W'(count_q);
	assign value_w = DATA_WIDTH'(cmd.value);

	always_comb begin
		do_insert   = 1'b0;
		do_remove   = 1'b0;
		status_nxt  = ST_DONE;
		removed_nxt = '1;
		count_nxt   = count_q;
		unique case (cmd.op)
			OP_INSERT: begin
				if (pos_x > cnt_x) begin
					status_nxt = ST_RANGE;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					status_nxt = ST_FULL;
				end else begin
					do_insert = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (pos_x >= cnt_x) begin
					status_nxt = ST_RANGE;
				end else begin
					do_remove   = 1'b1;
					removed_nxt = 32'(signed'(cell_data[cmd.position[IDX_W-1:0]]));
					count_nxt   = count_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
		cell_ctl_t             ctl;
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;

		// entries past the count are don't-care, so shifts need no upper bound
		assign ctl.load      = accept && do_insert && (IDX == pos_x);
		assign ctl.take_prev = accept && do_insert && (IDX > pos_x);
		assign ctl.take_next = accept && do_remove && (IDX >= pos_x);

		if (i == 0) begin : g_first
			assign prev_w = value_w;
		end else begin : g_mid
			assign prev_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = cell_data[i];
		end else begin : g_inner
			assign next_w = cell_data[i+1];
		end

		pirl_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.value     (value_w),
			.prev_data (prev_w),
			.next_data (next_w),
			.data_q    (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.removed_value <= signed'(removed_nxt);
			res_q.status        <= status_nxt;
			res_q.entry_count   <= 5'(count_nxt);
			res_q.is_empty      <= (count_nxt == '0);
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

[rtl/pirl_cell.sv]
module pirl_cell (
	input  logic                           clk,
	input  pirl_pkg::cell_ctl_t            ctl,
	input  logic [pirl_pkg::DATA_WIDTH-1:0] value,
	input  logic [pirl_pkg::DATA_WIDTH-1:0] prev_data,
	input  logic [pirl_pkg::DATA_WIDTH-1:0] next_data,
	output logic [pirl_pkg::DATA_WIDTH-1:0] data_q
);
	import pirl_pkg::*;

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			data_q <= value;
		end else if (ctl.take_prev) begin
			data_q <= prev_data;
		end else if (ctl.take_next) begin
			data_q <= next_data;
		end else begin
			data_q <= data_q;
		end
	end

endmodule
